[design/kcvt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kcvt_pkg: shared types and constants for the key:value line tokenizer
// Word types for both channels, the phase encoding, the tokenizer state
// record and the character codes the parser looks for.
// ----------------------------------------------------------------------------
package kcvt_pkg;

   localparam int TEXT_BYTES = 4096;
   localparam int MAX_PAIRS  = 254;

   localparam int POS_W   = 12;
   localparam int COUNT_W = 8;

   localparam logic [POS_W-1:0]   POS_LAST = POS_W'(TEXT_BYTES - 1);
   localparam logic [COUNT_W-1:0] PAIR_MAX = COUNT_W'(MAX_PAIRS);

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_PRINT_MIN = 8'd33;
   localparam logic [7:0] CH_HASH      = 8'h23;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

   typedef enum logic [5:0] {
      PH_SKIP     = 6'b000001,
      PH_COMMENT  = 6'b000010,
      PH_KEY      = 6'b000100,
      PH_PRECOLON = 6'b001000,
      PH_VALSPACE = 6'b010000,
      PH_VALUE    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte_in;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]         text_byte_out;
      logic               pair_valid;
      logic [POS_W-1:0]   key_pos;
      logic [POS_W-1:0]   value_pos;
      logic [COUNT_W-1:0] pair_total;
      logic               table_full;
      logic               done_res;
   } rsp_type;

   typedef struct packed {
      phase_type          phase;
      logic [POS_W-1:0]   byte_position;
      logic [POS_W-1:0]   key_start;
      logic [POS_W-1:0]   value_start;
      logic [COUNT_W-1:0] pair_count;
      logic               overflowed;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:         PH_SKIP,
      byte_position: '0,
      key_start:     '0,
      value_start:   '0,
      pair_count:    '0,
      overflowed:    1'b0
   };

endpackage
`default_nettype wire

[design/kcvt_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kcvt_step: one byte of the tokenizer phase machine
// Takes the current state and one input word, returns the next state and
// the result word for that byte. Purely combinational.
// ----------------------------------------------------------------------------
module kcvt_step (
   input  kcvt_pkg::state_type state_cur,
   input  kcvt_pkg::req_type   req_cur,
   output kcvt_pkg::state_type state_next,
   output kcvt_pkg::rsp_type   rsp_next
);
   import kcvt_pkg::*;

   function automatic logic is_letter(input logic [7:0] ch);
      return ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z)) ||
             ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z));
   endfunction

   logic [7:0]         ch;
   logic [7:0]         out_ch;
   logic               emit;
   logic               stored;
   phase_type          phase_eff;
   phase_type          phase_new;
   state_type          upd;

   assign ch = req_cur.text_byte_in;

   always_comb begin
      upd       = state_cur;
      out_ch    = ch;
      emit      = 1'b0;
      stored    = 1'b0;
      phase_eff = state_cur.phase;

      // leave the gap between items on the first printable byte
      if ((state_cur.phase == PH_SKIP) && (ch >= CH_PRINT_MIN)) begin
         if (ch == CH_HASH) begin
            phase_eff = PH_COMMENT;
         end else begin
            upd.key_start = state_cur.byte_position;
            phase_eff     = PH_KEY;
         end
      end

      phase_new = phase_eff;
      unique case (phase_eff)
         PH_SKIP: begin
         end
         PH_COMMENT: begin
            if ((ch == CH_LF) || (ch == CH_CR) || (ch == CH_NUL)) begin
               phase_new = PH_SKIP;
            end
         end
         PH_KEY: begin
            if (!is_letter(ch)) begin
               out_ch    = '0;
               phase_new = (ch == CH_COLON) ? PH_VALSPACE : PH_PRECOLON;
            end
         end
         PH_PRECOLON: begin
            if (ch >= CH_PRINT_MIN) begin
               if (ch == CH_COLON) begin
                  out_ch    = '0;
                  phase_new = PH_VALSPACE;
               end else begin
                  // no colon after the key: drop the rest of the line
                  phase_new = PH_COMMENT;
               end
            end
         end
         PH_VALSPACE: begin
            if (ch >= CH_PRINT_MIN) begin
               upd.value_start = state_cur.byte_position;
               if (ch <= CH_LOWER_Z) begin
                  phase_new = PH_VALUE;
               end else begin
                  // empty value: terminate at once
                  out_ch    = '0;
                  emit      = 1'b1;
                  phase_new = PH_SKIP;
               end
            end
         end
         PH_VALUE: begin
            if ((ch < CH_PRINT_MIN) || (ch > CH_LOWER_Z)) begin
               out_ch    = '0;
               emit      = 1'b1;
               phase_new = PH_SKIP;
            end
         end
         default: begin
            phase_new = PH_SKIP;
         end
      endcase
      upd.phase = phase_new;

      // a value still open on the last byte completes there
      if (req_cur.final_byte && (phase_new == PH_VALUE)) begin
         emit = 1'b1;
      end

      if (emit) begin
         if (state_cur.pair_count < PAIR_MAX) begin
            upd.pair_count = state_cur.pair_count + 1'b1;
            stored         = 1'b1;
         end else begin
            upd.overflowed = 1'b1;
         end
      end

      rsp_next.text_byte_out = out_ch;
      rsp_next.pair_valid    = stored;
      rsp_next.key_pos       = stored ? upd.key_start : '0;
      rsp_next.value_pos     = stored ? upd.value_start : '0;
      rsp_next.pair_total    = upd.pair_count;
      rsp_next.table_full    = upd.overflowed;
      rsp_next.done_res      = req_cur.final_byte;

      if (state_cur.byte_position != POS_LAST) begin
         upd.byte_position = state_cur.byte_position + 1'b1;
      end

      state_next = req_cur.final_byte ? STATE_RESET : upd;
   end

endmodule
`default_nettype wire

[design/key_colon_value_line_tokenizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// key_colon_value_line_tokenizer: streaming key:value text tokenizer
// Splits configuration text, one byte per word, into key:value pairs.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one text byte per word, final_byte marks the end of a text.
//   rsp channel: exactly one word per req word, in order. It carries the
//   byte (zero where a terminator goes), the key and value offsets when a
//   pair completes on that byte, the running pair count and the full flag.
//   Path: an accepted word waits in the input register, then one pass of
//   the phase logic writes its result into the result register, which
//   drives rsp.
//   Throughput: one word per cycle, sustained, while rsp is not stalled.
//   Stall: rsp_stall holds a full result register; the input register still
//   takes one more word, and req_stall stays high while it holds that word.
//   Reset: both registers empty, phase machine back to skipping space,
//   positions and pair count at zero. The last byte of a text also returns
//   the state to these values, so the next word starts a new text.
//   Positions saturate at TEXT_BYTES-1; pairs past MAX_PAIRS are dropped
//   and table_full stays set until the end of the text.
// ----------------------------------------------------------------------------
module key_colon_value_line_tokenizer (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  kcvt_pkg::req_type   req_word,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output kcvt_pkg::rsp_type   rsp_word
);
   import kcvt_pkg::*;

   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_word_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_word_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   rsp_calc;
   logic      advance;
   logic      accept;

   kcvt_step u_step (
      .state_cur  (state_ff),
      .req_cur    (in_word_ff),
      .state_next (state_in),
      .rsp_next   (rsp_calc)
   );

   // advance the held word into the result register when it is free
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= rsp_calc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_phase_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff.phase))
      else $error("tokenizer phase is not one-hot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.pair_count <= PAIR_MAX)
      else $error("pair count beyond table size");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_word_ff.final_byte) |=>
         (state_ff.pair_count == '0) && (state_ff.phase == PH_SKIP) &&
         (state_ff.byte_position == '0) && !state_ff.overflowed)
      else $error("state not cleared after last byte");

   a_key_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.pair_valid) |->
         (rsp_word_ff.key_pos <= rsp_word_ff.value_pos))
      else $error("pair value starts before its key");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled result lost");
`endif

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: key:value line tokenizer testbench
// Feeds configuration text one byte per word: a few hand-built texts, one
// long text that fills the pair table and overflows it, then random texts
// built mostly from well-formed key:value lines.
// A scoreboard tracks the parser's phase and counters, predicts every
// result word and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
import kcvt_pkg::*;

function automatic bit is_key_letter(logic [7:0] c);
   return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
endfunction

function automatic string rsp_text(rsp_type r);
   return $sformatf("byte=%02h pair=%0b key=%0d value=%0d total=%0d full=%0b done=%0b",
                    r.text_byte_out, r.pair_valid, r.key_pos, r.value_pos,
                    r.pair_total, r.table_full, r.done_res);
endfunction

class pair_scoreboard;
   phase_type          phase;
   logic [POS_W-1:0]   byte_pos;
   logic [POS_W-1:0]   key_start;
   logic [POS_W-1:0]   value_start;
   logic [COUNT_W-1:0] pair_count;
   logic               overflowed;
   rsp_type            expected_q[$];
   int                 mismatches;

   function new();
      mismatches = 0;
      restart_text();
   endfunction

   function void restart_text();
      phase       = PH_SKIP;
      byte_pos    = '0;
      key_start   = '0;
      value_start = '0;
      pair_count  = '0;
      overflowed  = 1'b0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // Advance the parser by one accepted byte and queue the result it causes.
   function void note_input(req_type w);
      logic [7:0] c;
      rsp_type    exp_word;
      bit         emit;
      c        = w.text_byte_in;
      exp_word = '0;
      emit     = 0;
      exp_word.text_byte_out = c;
      exp_word.done_res      = w.final_byte;

      if (phase == PH_SKIP && c >= CH_PRINT_MIN) begin
         if (c == CH_HASH) begin
            phase = PH_COMMENT;
         end else begin
            key_start = byte_pos;
            phase     = PH_KEY;
         end
      end

      case (phase)
         PH_COMMENT: begin
            if (c == CH_LF || c == CH_CR || c == CH_NUL) phase = PH_SKIP;
         end
         PH_KEY: begin
            if (!is_key_letter(c)) begin
               exp_word.text_byte_out = '0;
               phase = (c == CH_COLON) ? PH_VALSPACE : PH_PRECOLON;
            end
         end
         PH_PRECOLON: begin
            if (c == CH_COLON) begin
               exp_word.text_byte_out = '0;
               phase = PH_VALSPACE;
            end else if (c >= CH_PRINT_MIN) begin
               phase = PH_COMMENT;
            end
         end
         PH_VALSPACE: begin
            if (c >= CH_PRINT_MIN) begin
               value_start = byte_pos;
               if (c <= CH_LOWER_Z) begin
                  phase = PH_VALUE;
               end else begin
                  exp_word.text_byte_out = '0;
                  emit  = 1;
                  phase = PH_SKIP;
               end
            end
         end
         PH_VALUE: begin
            if (c < CH_PRINT_MIN || c > CH_LOWER_Z) begin
               exp_word.text_byte_out = '0;
               emit  = 1;
               phase = PH_SKIP;
            end
         end
         default: ;
      endcase

      // a value still open on the last byte completes there
      if (w.final_byte && phase == PH_VALUE) emit = 1;

      if (emit) begin
         if (pair_count < PAIR_MAX) begin
            pair_count         = pair_count + 1'b1;
            exp_word.pair_valid = 1'b1;
            exp_word.key_pos    = key_start;
            exp_word.value_pos  = value_start;
         end else begin
            overflowed = 1'b1;
         end
      end
      exp_word.pair_total = pair_count;
      exp_word.table_full = overflowed;

      if (byte_pos < POS_LAST) byte_pos = byte_pos + 1'b1;
      if (w.final_byte) restart_text();
      expected_q.push_back(exp_word);
   endfunction

   function void check_result(rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result word: %s", rsp_text(got));
         return;
      end
      want = expected_q.pop_front();
      if (got.text_byte_out !== want.text_byte_out || got.pair_valid !== want.pair_valid ||
          got.key_pos !== want.key_pos || got.value_pos !== want.value_pos ||
          got.pair_total !== want.pair_total || got.table_full !== want.table_full ||
          got.done_res !== want.done_res) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: expected %s", rsp_text(want));
            $display("          actual   %s", rsp_text(got));
         end
      end
   endfunction
endclass

module tb;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_word  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_word;

   pair_scoreboard sb;
   logic [7:0]     text_q[$];
   bit             calm       = 0;
   int             items_sent = 0;
   int             stall_left = 0;
   int             run_left   = 0;

   key_colon_value_line_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #10 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver side: alternate runs of ready cycles with stall bursts
   always @(posedge clock) begin
      if (stall_left == 0 && run_left == 0) begin
         run_left   = $urandom_range(1, 12);
         stall_left = pick_gap();
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         run_left--;
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_input(req_word);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_word);
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{text_byte_in: b, final_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // send the queued text, final_byte on its last byte
   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) send_word(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   function automatic void load_string(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] rand_letter();
      int r;
      r = $urandom_range(51);
      return (r < 26) ? CH_UPPER_A + 8'(r) : CH_LOWER_A + 8'(r - 26);
   endfunction

   function automatic logic [7:0] rand_blank();
      return 8'($urandom_range(0, 32));
   endfunction

   function automatic void add_blanks(int most);
      repeat ($urandom_range(0, most)) text_q.push_back(rand_blank());
   endfunction

   function automatic void add_key();
      repeat ($urandom_range(1, 8)) text_q.push_back(rand_letter());
   endfunction

   // any byte that ends a key without being its colon
   function automatic logic [7:0] rand_key_end();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (is_key_letter(b) || b == CH_COLON);
      return b;
   endfunction

   function automatic void add_pair_line();
      add_blanks(2);
      add_key();
      if ($urandom_range(2) != 0) begin
         text_q.push_back(CH_COLON);
      end else begin
         text_q.push_back(($urandom_range(1) == 0) ? rand_blank() : rand_key_end());
         add_blanks(2);
         text_q.push_back(CH_COLON);
      end
      add_blanks(2);
      if ($urandom_range(9) == 0) begin
         // empty value: first byte above 'z'
         text_q.push_back(8'($urandom_range(123, 255)));
      end else begin
         repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(33, 122)));
         if ($urandom_range(3) == 0) text_q.push_back(8'($urandom_range(123, 255)));
         else text_q.push_back(rand_blank());
      end
   endfunction

   function automatic void add_comment_line();
      logic [7:0] b;
      text_q.push_back(CH_HASH);
      repeat ($urandom_range(0, 10)) begin
         do b = 8'($urandom_range(255)); while (b == CH_LF || b == CH_CR || b == CH_NUL);
         text_q.push_back(b);
      end
      case ($urandom_range(2))
         0: text_q.push_back(CH_LF);
         1: text_q.push_back(CH_CR);
         default: text_q.push_back(CH_NUL);
      endcase
   endfunction

   // key followed by something other than a colon: rest of line dropped
   function automatic void add_broken_line();
      logic [7:0] b;
      add_key();
      text_q.push_back(rand_key_end());
      add_blanks(2);
      do b = 8'($urandom_range(33, 255)); while (b == CH_COLON);
      text_q.push_back(b);
      repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(33, 255)));
      text_q.push_back(CH_LF);
   endfunction

   function automatic void add_random_text();
      int lines, r, cut;
      lines = $urandom_range(1, 10);
      repeat (lines) begin
         r = $urandom_range(99);
         if (r < 60) add_pair_line();
         else if (r < 72) add_comment_line();
         else if (r < 84) add_broken_line();
         else repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
      end
      // cut some texts short so they end inside a key, a value or a comment
      if ($urandom_range(9) < 3) begin
         cut = $urandom_range(1, text_q.size());
         while (text_q.size() > cut) void'(text_q.pop_back());
      end
   endfunction

   initial begin
      int waited;
      sb = new;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // value still open on the last byte
      load_string("Ab:z");
      send_text();
      // key ends in a line break, colon on the next line, value above 'z'
      text_q.push_back(8'h20);
      load_string("k\n:{");
      text_q.push_back(8'hFF);
      send_text();
      // comment, then a value terminated by a zero byte on the last byte
      load_string("#x\rZ:!");
      text_q.push_back(8'h00);
      send_text();
      text_q.push_back(8'h00);
      send_text();
      load_string("q");
      send_text();
      load_string("m x\n");
      send_text();

      // long text: the pair table fills, then overflows
      repeat (5) add_pair_line();
      repeat (260) load_string("a:b\n");
      load_string("c:d");
      send_text();

      while (items_sent < 1450) begin
         calm = ($urandom_range(4) == 0);
         add_random_text();
         send_text();
      end
      calm = 0;
      req_valid <= 1'b0;

      waited = 0;
      while (sb.pending() > 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
